>>> design/assert_macros.svh
// Assertion macros for the handle table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> design/gcht_pkg.sv
// Shared types, codes and tables of the handle table
`timescale 1ns / 1ps
package gcht_pkg;
    localparam int SLOT_COUNT_DEF = 64;
    localparam longint GEN_LIMIT_DEF = 65535;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_RESERVE = 3'd1;
    localparam logic [2:0] OP_PUBLISH = 3'd2;
    localparam logic [2:0] OP_ABORT   = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;
    localparam logic [2:0] OP_DETACH  = 3'd5;
    localparam logic [2:0] OP_REPLACE = 3'd6;

    localparam logic [2:0] R_OK    = 3'd0;
    localparam logic [2:0] R_INVAL = 3'd1;
    localparam logic [2:0] R_PERM  = 3'd2;
    localparam logic [2:0] R_STATE = 3'd3;
    localparam logic [2:0] R_OVER  = 3'd4;
    localparam logic [2:0] R_FULL  = 3'd5;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_RESERVED = 2'd1;
    localparam logic [1:0] ST_LIVE     = 2'd2;
    localparam logic [1:0] ST_RETIRED  = 2'd3;

    localparam logic [7:0] RIGHT_DUP = 8'h10;

    // one slot entry as stored in the table memory
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] gen;
        logic [31:0] obj;
        logic [3:0]  otype;
        logic [7:0]  rights;
        logic [63:0] nonce;
        logic [3:0]  rtype;
    } slot_t;

    function automatic logic [7:0] allowed_rights(input logic [3:0] t);
        logic [7:0] r;
        begin
            case (t)
                4'd1, 4'd2, 4'd3:  r = 8'hFC;
                4'd4, 4'd5, 4'd9:  r = 8'hF7;
                4'd6:              r = 8'hC7;
                4'd7:              r = 8'hF4;
                4'd8:              r = 8'hF3;
                4'd10:             r = 8'hFF;
                default:           r = 8'h00;
            endcase
            return r;
        end
    endfunction
endpackage

>>> design/gcht_mem.sv
// Slot memory with per-entry valid bits; invalid entries read as all zeros
`timescale 1ns / 1ps
module gcht_mem #(
    parameter int SLOT_COUNT = gcht_pkg::SLOT_COUNT_DEF,
    parameter int AW = $clog2(SLOT_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [AW-1:0]        raddr,
    output gcht_pkg::slot_t      rdata,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  gcht_pkg::slot_t      wdata
);
    import gcht_pkg::*;

    slot_t mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    slot_t rd_reg;
    logic  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;
endmodule

>>> design/generation_checked_handle_table_top.sv
// Handle table top level: command sequencer around the slot memory
`timescale 1ns / 1ps
// One command at a time: start is taken while busy is low, and the result shows for one
// cycle with done high. busy stays high through that done cycle, so the next command can
// be taken in the cycle after the result. Handle operations (publish, abort, lookup,
// detach, replace) read the slot (one memory read with registered data), check it and
// write back any change before the result is put out. Insert and reserve scan round-robin
// from the slot after the last one allocated, reading then checking one slot at a time
// through the single read port; a request rejected before the scan skips it. Free slots
// at the generation maximum are retired as the scan passes. No clearing pass after reset.
module generation_checked_handle_table_top #(
    parameter int     SLOT_COUNT = gcht_pkg::SLOT_COUNT_DEF,
    parameter longint GENERATION_LIMIT = gcht_pkg::GEN_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  op,
    input  logic [5:0]  slot_index,
    input  logic [15:0] generation,
    input  logic [31:0] object_id,
    input  logic [3:0]  obj_kind,
    input  logic        object_alive,
    input  logic [7:0]  rights_mask,
    input  logic [3:0]  match_kind,
    input  logic [63:0] resv_nonce,
    output logic [2:0]  status,
    output logic [5:0]  out_slot,
    output logic [15:0] out_generation,
    output logic [31:0] out_object,
    output logic [7:0]  out_rights,
    output logic [63:0] out_nonce
);
    import gcht_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam logic [15:0] GEN_MAX =
        (GENERATION_LIMIT < 65535) ? 16'(GENERATION_LIMIT) : 16'hFFFF;
    localparam logic [AW:0] SLOT_CNT = (AW+1)'(SLOT_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_SCHK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] last_alloc_reg, last_alloc_next;
    logic [63:0]   last_nonce_reg, last_nonce_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW:0]   cnt_reg, cnt_next;

    logic [2:0]  op_reg;
    logic [5:0]  si_reg;
    logic [15:0] gen_reg;
    logic [31:0] obj_reg;
    logic [3:0]  typ_reg, et_reg;
    logic        alive_reg;
    logic [7:0]  rm_reg;
    logic [63:0] nonce_reg;

    logic [2:0]  st_reg, st_next;
    logic [5:0]  os_reg, os_next;
    logic [15:0] og_reg, og_next;
    logic [31:0] oo_reg, oo_next;
    logic [7:0]  or_reg, or_next;
    logic [63:0] on_reg, on_next;
    logic        done_reg, done_next;

    logic [AW-1:0] raddr;
    slot_t rdata, wdata;
    logic we;
    logic [AW-1:0] waddr;

    logic take;
    logic slot_ok, live_m, res_m;
    logic [7:0] req_allowed, pub_allowed;
    logic [AW-1:0] idx_inc;

    gcht_mem #(.SLOT_COUNT(SLOT_COUNT), .AW(AW)) u_mem (
        .clk(clk), .rst_n(rst_n), .raddr(raddr), .rdata(rdata),
        .we(we), .waddr(waddr), .wdata(wdata)
    );

    assign take = start && !busy;
    assign slot_ok = {26'd0, si_reg} < 32'(SLOT_COUNT);
    assign live_m = rdata.status == ST_LIVE && rdata.obj != '0 && rdata.gen == gen_reg
        && rdata.nonce == '0 && rdata.rtype == '0;
    assign res_m = rdata.status == ST_RESERVED && rdata.obj == '0 && rdata.gen == gen_reg
        && rdata.nonce == nonce_reg && rdata.rtype != '0 && rdata.rights != '0;
    assign req_allowed = allowed_rights(typ_reg);
    assign pub_allowed = allowed_rights(typ_reg);
    assign idx_inc = (32'(idx_reg) == SLOT_COUNT - 1) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        raddr = slot_ok ? AW'(si_reg) : '0;
        if (state_reg == S_SREAD || state_reg == S_SCHK)
            raddr = idx_reg;
    end

    always_comb
    begin
        slot_t cleared;
        state_next = state_reg;
        last_alloc_next = last_alloc_reg;
        last_nonce_next = last_nonce_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        st_next = st_reg;
        os_next = os_reg;
        og_next = og_reg;
        oo_next = oo_reg;
        or_next = or_reg;
        on_next = on_reg;
        done_next = 1'b0;
        we = 1'b0;
        waddr = raddr;
        wdata = rdata;
        cleared = '0;
        cleared.gen = rdata.gen;
        cleared.status = (rdata.gen == GEN_MAX) ? ST_RETIRED : ST_FREE;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    st_next = R_OK;
                    os_next = '0;
                    og_next = '0;
                    oo_next = '0;
                    or_next = '0;
                    on_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // memory read data is ready next cycle
                state_next = S_EXEC;
                if (op_reg == OP_INSERT || op_reg == OP_RESERVE)
                begin
                    state_next = S_DONE;
                    if ((op_reg == OP_INSERT && obj_reg == '0) || typ_reg == '0
                        || rm_reg == '0)
                        st_next = R_INVAL;
                    else if ((rm_reg & ~req_allowed) != '0)
                        st_next = R_PERM;
                    else if (op_reg == OP_INSERT && !alive_reg)
                        st_next = R_STATE;
                    else
                    begin
                        idx_next = (32'(last_alloc_reg) == SLOT_COUNT - 1) ? '0
                            : last_alloc_reg + 1'b1;
                        cnt_next = '0;
                        state_next = S_SREAD;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_PUBLISH:
                    begin
                        if (nonce_reg == '0 || !slot_ok || obj_reg == '0 || typ_reg == '0)
                            st_next = R_INVAL;
                        else if (!alive_reg)
                            st_next = R_STATE;
                        else if (!res_m || rdata.rtype != typ_reg)
                            st_next = R_INVAL;
                        else if ((rdata.rights & ~pub_allowed) != '0)
                            st_next = R_PERM;
                        else
                        begin
                            we = 1'b1;
                            wdata.obj = obj_reg;
                            wdata.otype = typ_reg;
                            wdata.nonce = '0;
                            wdata.rtype = '0;
                            wdata.status = ST_LIVE;
                            os_next = si_reg;
                            og_next = gen_reg;
                        end
                    end
                    OP_ABORT:
                    begin
                        if (nonce_reg == '0 || !slot_ok || !res_m)
                            st_next = R_INVAL;
                        else
                        begin
                            we = 1'b1;
                            wdata = cleared;
                        end
                    end
                    OP_LOOKUP, OP_DETACH:
                    begin
                        if (!slot_ok || !live_m)
                            st_next = R_INVAL;
                        else if (et_reg != '0 && rdata.otype != et_reg)
                            st_next = R_INVAL;
                        else if ((rdata.rights & rm_reg) != rm_reg)
                            st_next = R_PERM;
                        else
                        begin
                            oo_next = rdata.obj;
                            if (op_reg == OP_LOOKUP)
                                or_next = rdata.rights;
                            else
                            begin
                                we = 1'b1;
                                wdata = cleared;
                            end
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (!slot_ok || rm_reg == '0 || !live_m)
                            st_next = R_INVAL;
                        else if ((rdata.rights & RIGHT_DUP) == '0
                            || (rm_reg & ~rdata.rights) != '0)
                            st_next = R_PERM;
                        else if (rdata.gen == GEN_MAX)
                            st_next = R_OVER;
                        else
                        begin
                            we = 1'b1;
                            wdata.gen = rdata.gen + 16'd1;
                            wdata.rights = rm_reg;
                            os_next = si_reg;
                            og_next = rdata.gen + 16'd1;
                        end
                    end
                    default:
                        st_next = R_INVAL;
                endcase
            end
            S_SREAD:
                state_next = S_SCHK;
            S_SCHK:
            begin
                state_next = S_SREAD;
                idx_next = idx_inc;
                cnt_next = cnt_reg + 1'b1;
                if (idx_reg != '0 && rdata.status == ST_FREE)
                begin
                    if (rdata.gen == GEN_MAX)
                    begin
                        we = 1'b1;
                        wdata.status = ST_RETIRED;
                    end
                    else
                    begin
                        state_next = S_DONE;
                        if (op_reg == OP_RESERVE && last_nonce_reg == '1)
                            st_next = R_OVER;
                        else
                        begin
                            we = 1'b1;
                            wdata.gen = rdata.gen + 16'd1;
                            wdata.rights = rm_reg;
                            if (op_reg == OP_RESERVE)
                            begin
                                last_nonce_next = last_nonce_reg + 64'd1;
                                wdata.nonce = last_nonce_reg + 64'd1;
                                wdata.rtype = typ_reg;
                                wdata.status = ST_RESERVED;
                                on_next = last_nonce_reg + 64'd1;
                            end
                            else
                            begin
                                wdata.obj = obj_reg;
                                wdata.otype = typ_reg;
                                wdata.nonce = '0;
                                wdata.rtype = '0;
                                wdata.status = ST_LIVE;
                            end
                            last_alloc_next = idx_reg;
                            os_next = 6'(idx_reg);
                            og_next = rdata.gen + 16'd1;
                        end
                    end
                end
                if (state_next == S_SREAD && cnt_reg + 1'b1 == SLOT_CNT)
                begin
                    st_next = R_FULL;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_alloc_reg <= '0;
            last_nonce_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_alloc_reg <= last_alloc_next;
            last_nonce_reg <= last_nonce_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        st_reg <= st_next;
        os_reg <= os_next;
        og_reg <= og_next;
        oo_reg <= oo_next;
        or_reg <= or_next;
        on_reg <= on_next;
        if (state_reg == S_IDLE && take)
        begin
            op_reg    <= op;
            si_reg    <= slot_index;
            gen_reg   <= generation;
            obj_reg   <= object_id;
            typ_reg   <= obj_kind;
            alive_reg <= object_alive;
            rm_reg    <= rights_mask;
            et_reg    <= match_kind;
            nonce_reg <= resv_nonce;
        end
    end

    assign busy = state_reg != S_IDLE || done_reg;
    assign done = done_reg;
    assign status = st_reg;
    assign out_slot = os_reg;
    assign out_generation = og_reg;
    assign out_object = oo_reg;
    assign out_rights = or_reg;
    assign out_nonce = on_reg;
endmodule

>>> design/gcht_checker.sv
// Port-level checker for the handle table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gcht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [5:0]  out_slot,
    input logic [15:0] out_generation,
    input logic [31:0] out_object,
    input logic [63:0] out_nonce
);
    import gcht_pkg::*;

    logic outs_zero;

    assign outs_zero = out_slot == '0 && out_generation == '0 && out_object == '0
        && out_nonce == '0;

    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `CHK_IMPLY(a_done_busy, clk, rst_n, done, busy)
    `CHK_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `CHK_IMPLY(a_err_zero, clk, rst_n, done && status != R_OK, outs_zero)
    `CHK_IMPLY(a_status_range, clk, rst_n, done, status <= R_FULL)
endmodule

bind generation_checked_handle_table_top gcht_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .out_slot(out_slot), .out_generation(out_generation),
    .out_object(out_object), .out_nonce(out_nonce)
);
